// File: hdl/mlfq_pkg.sv
package mlfq_pkg;

    localparam int NUM_TASKS = 64;
    localparam int TW = $clog2(NUM_TASKS);
    localparam int LW = TW + 1;

    localparam logic [2:0] OP_ADMIT = 3'd0;
    localparam logic [2:0] OP_SLEEP = 3'd1;
    localparam logic [2:0] OP_WAKE  = 3'd2;
    localparam logic [2:0] OP_EXIT  = 3'd3;
    localparam logic [2:0] OP_PICK  = 3'd4;

    localparam logic [1:0] MODE_UNUSED = 2'd0;
    localparam logic [1:0] MODE_READY  = 2'd1;
    localparam logic [1:0] MODE_ASLEEP = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_NOTHING = 2'd2;

    localparam logic [1:0] TOP_LEVEL = 2'd3;

    localparam logic [2:0] REG_SLICE3  = 3'd0;
    localparam logic [2:0] REG_SLICE2  = 3'd1;
    localparam logic [2:0] REG_SLICE1  = 3'd2;
    localparam logic [2:0] REG_STARVE0 = 3'd3;
    localparam logic [2:0] REG_STARVE1 = 3'd4;
    localparam logic [2:0] REG_STARVE2 = 3'd5;

    localparam logic [6:0] PROMO_MAX = 7'd127;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_READ,
        CMD_ADMIT,
        CMD_REMOVE,
        CMD_WAKE,
        CMD_PROMO,
        CMD_HEAD
    } cmd_t;

    typedef struct packed {
        cmd_t            cmd;
        logic [TW-1:0]   tsel;
        logic [1:0]      lv;
        logic [TW-1:0]   pos;
        logic [TW-1:0]   app_pos;
        logic [1:0]      next_mode;
        logic            shift;
        logic [15:0]     starve_lim;
        logic [7:0]      slice_lim;
    } bcast_t;

    typedef struct packed {
        logic            hit;
        logic            flag;
        logic [TW-1:0]   idx;
        logic [1:0]      mode;
        logic [1:0]      level;
        logic [TW-1:0]   pos;
    } chain_t;

endpackage

// File: hdl/multilevel_feedback_scheduler.sv
// Four-level feedback scheduler over NUM_TASKS task slots, built as a row of
// task cells, one per slot, each keeping its mode, level, queue place, slice
// and wait counts; a controller broadcasts one command a cycle and the cells
// hand their answer down the row. Admit, sleep, wake and exit read the slot,
// apply the change and load the output register. A pick walks the queues of
// levels 0 to 2 one queue place a cycle while no task there is promoted, then
// takes the head of the highest non-empty level. One item is worked on at a
// time; the next item is taken while the result still waits in the output
// register.
module multilevel_feedback_scheduler
    import mlfq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // op[2:0], task_req[8:3]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // status, chosen_task, chosen_level, demoted, promoted_count
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_APPLY = 6'b000100,
        S_SCAN  = 6'b001000,
        S_HEAD  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    logic [2:0]    op_reg, op_next;
    logic [5:0]    req_reg, req_next;
    logic [1:0]    lv_reg, lv_next;
    logic [LW-1:0] j_reg, j_next;
    logic [6:0]    promos_reg, promos_next;
    logic [1:0]    rd_mode_reg, rd_mode_next;
    logic [1:0]    rd_level_reg, rd_level_next;
    logic [TW-1:0] rd_pos_reg, rd_pos_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic [5:0]    res_task_reg, res_task_next;
    logic [1:0]    res_level_reg, res_level_next;
    logic          res_dem_reg, res_dem_next;
    logic [LW-1:0] len_reg [4];
    logic [LW-1:0] len_next [4];

    logic          out_valid_reg;
    logic [1:0]    out_status_reg;
    logic [5:0]    out_task_reg;
    logic [1:0]    out_level_reg;
    logic          out_dem_reg;
    logic [6:0]    out_promos_reg;

    logic [7:0]    slice3_reg, slice2_reg, slice1_reg;
    logic [15:0]   starve0_reg, starve1_reg, starve2_reg;

    bcast_t        bc;
    chain_t        chain_w [NUM_TASKS+1];
    chain_t        chain_end;
    logic          any_flag;

    logic          in_fire;
    logic          cfg_wr;
    logic [2:0]    cfg_idx;
    logic [1:0]    clv;
    logic          found;
    logic [7:0]    slice_lim_sel;
    logic [15:0]   starve_sel;

    assign chain_w[0] = '0;
    assign chain_end  = chain_w[NUM_TASKS];
    assign any_flag   = chain_end.flag;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_TASKS; gi++)
        begin : g_cell
            mlfq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cell_idx  (TW'(gi)),
                .bc        (bc),
                .any_flag  (any_flag),
                .chain_in  (chain_w[gi]),
                .chain_out (chain_w[gi+1])
            );
        end
    endgenerate

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_promos_reg, out_dem_reg, out_level_reg,
                       out_task_reg, out_status_reg};

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_comb
    begin
        unique case (cfg_idx)
            REG_SLICE3:  prdata = {24'd0, slice3_reg};
            REG_SLICE2:  prdata = {24'd0, slice2_reg};
            REG_SLICE1:  prdata = {24'd0, slice1_reg};
            REG_STARVE0: prdata = {16'd0, starve0_reg};
            REG_STARVE1: prdata = {16'd0, starve1_reg};
            REG_STARVE2: prdata = {16'd0, starve2_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // highest non-empty level
    always_comb
    begin
        found = 1'b1;
        if (len_reg[3] != '0)
            clv = 2'd3;
        else if (len_reg[2] != '0)
            clv = 2'd2;
        else if (len_reg[1] != '0)
            clv = 2'd1;
        else if (len_reg[0] != '0)
            clv = 2'd0;
        else
        begin
            clv   = 2'd0;
            found = 1'b0;
        end
    end

    always_comb
    begin
        case (clv)
            2'd3:    slice_lim_sel = slice3_reg;
            2'd2:    slice_lim_sel = slice2_reg;
            2'd1:    slice_lim_sel = slice1_reg;
            default: slice_lim_sel = 8'd0;
        endcase
        case (lv_reg)
            2'd0:    starve_sel = starve0_reg;
            2'd1:    starve_sel = starve1_reg;
            default: starve_sel = starve2_reg;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        req_next        = req_reg;
        lv_next         = lv_reg;
        j_next          = j_reg;
        promos_next     = promos_reg;
        rd_mode_next    = rd_mode_reg;
        rd_level_next   = rd_level_reg;
        rd_pos_next     = rd_pos_reg;
        res_status_next = res_status_reg;
        res_task_next   = res_task_reg;
        res_level_next  = res_level_reg;
        res_dem_next    = res_dem_reg;
        for (int k = 0; k < 4; k++)
            len_next[k] = len_reg[k];
        bc = '0;
        bc.cmd = CMD_NONE;

        unique case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    op_next         = s_tdata[2:0];
                    req_next        = s_tdata[8:3];
                    lv_next         = 2'd0;
                    j_next          = '0;
                    promos_next     = 7'd0;
                    res_status_next = ST_IGNORED;
                    res_task_next   = 6'd0;
                    res_level_next  = 2'd0;
                    res_dem_next    = 1'b0;
                    if (s_tdata[2:0] == OP_PICK)
                        state_next = S_SCAN;
                    else if ((s_tdata[2:0] <= OP_EXIT) && (32'(s_tdata[8:3]) < NUM_TASKS))
                        state_next = S_READ;
                    else
                        state_next = S_DONE;
                end
            S_READ:
            begin
                bc.cmd        = CMD_READ;
                bc.tsel       = TW'(req_reg);
                rd_mode_next  = chain_end.mode;
                rd_level_next = chain_end.level;
                rd_pos_next   = chain_end.pos;
                state_next    = S_APPLY;
            end
            S_APPLY:
            begin
                bc.tsel    = TW'(req_reg);
                bc.lv      = rd_level_reg;
                bc.pos     = rd_pos_reg;
                state_next = S_DONE;
                case (op_reg)
                    OP_ADMIT:
                        if (rd_mode_reg == MODE_UNUSED)
                        begin
                            bc.cmd          = CMD_ADMIT;
                            bc.app_pos      = TW'(len_reg[3]);
                            len_next[3]     = len_reg[3] + 1'b1;
                            res_status_next = ST_DONE;
                        end
                    OP_SLEEP:
                        if (rd_mode_reg == MODE_READY)
                        begin
                            bc.cmd                = CMD_REMOVE;
                            bc.next_mode          = MODE_ASLEEP;
                            bc.shift              = 1'b1;
                            len_next[rd_level_reg] = len_reg[rd_level_reg] - 1'b1;
                            res_status_next       = ST_DONE;
                        end
                    OP_WAKE:
                        if (rd_mode_reg == MODE_ASLEEP)
                        begin
                            bc.cmd                = CMD_WAKE;
                            bc.app_pos            = TW'(len_reg[rd_level_reg]);
                            len_next[rd_level_reg] = len_reg[rd_level_reg] + 1'b1;
                            res_status_next       = ST_DONE;
                        end
                    default:
                        if (rd_mode_reg != MODE_UNUSED)
                        begin
                            bc.cmd          = CMD_REMOVE;
                            bc.next_mode    = MODE_UNUSED;
                            bc.shift        = (rd_mode_reg == MODE_READY);
                            if (rd_mode_reg == MODE_READY)
                                len_next[rd_level_reg] = len_reg[rd_level_reg] - 1'b1;
                            res_status_next = ST_DONE;
                        end
                endcase
            end
            S_SCAN:
                if (j_reg >= len_reg[lv_reg])
                begin
                    if (lv_reg == 2'd2)
                        state_next = S_HEAD;
                    else
                    begin
                        lv_next = lv_reg + 2'd1;
                        j_next  = '0;
                    end
                end
                else
                begin
                    bc.cmd        = CMD_PROMO;
                    bc.lv         = lv_reg;
                    bc.pos        = TW'(j_reg);
                    bc.starve_lim = starve_sel;
                    bc.app_pos    = TW'(len_reg[lv_reg + 2'd1]);
                    if (any_flag)
                    begin
                        len_next[lv_reg]        = len_reg[lv_reg] - 1'b1;
                        len_next[lv_reg + 2'd1] = len_reg[lv_reg + 2'd1] + 1'b1;
                        if (promos_reg != PROMO_MAX)
                            promos_next = promos_reg + 7'd1;
                    end
                    else
                        j_next = j_reg + 1'b1;
                end
            S_HEAD:
            begin
                state_next = S_DONE;
                if (!found)
                    res_status_next = ST_NOTHING;
                else
                begin
                    bc.cmd          = CMD_HEAD;
                    bc.lv           = clv;
                    bc.slice_lim    = slice_lim_sel;
                    bc.app_pos      = TW'(len_reg[clv - 2'd1]);
                    res_status_next = ST_DONE;
                    res_task_next   = 6'(chain_end.idx);
                    res_level_next  = clv - {1'b0, any_flag};
                    res_dem_next    = any_flag;
                    if (any_flag)
                    begin
                        len_next[clv]        = len_reg[clv] - 1'b1;
                        len_next[clv - 2'd1] = len_reg[clv - 2'd1] + 1'b1;
                    end
                end
            end
            S_DONE:
                if (!out_valid_reg || m_tready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 4; k++)
                len_reg[k] <= '0;
            slice3_reg    <= 8'd8;
            slice2_reg    <= 8'd16;
            slice1_reg    <= 8'd32;
            starve0_reg   <= 16'd500;
            starve1_reg   <= 16'd320;
            starve2_reg   <= 16'd160;
        end
        else
        begin
            state_reg <= state_next;
            for (int k = 0; k < 4; k++)
                len_reg[k] <= len_next[k];
            if ((state_reg == S_DONE) && (!out_valid_reg || m_tready))
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    REG_SLICE3:  slice3_reg  <= pwdata[7:0];
                    REG_SLICE2:  slice2_reg  <= pwdata[7:0];
                    REG_SLICE1:  slice1_reg  <= pwdata[7:0];
                    REG_STARVE0: starve0_reg <= pwdata[15:0];
                    REG_STARVE1: starve1_reg <= pwdata[15:0];
                    REG_STARVE2: starve2_reg <= pwdata[15:0];
                    default:     slice3_reg  <= slice3_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        req_reg        <= req_next;
        lv_reg         <= lv_next;
        j_reg          <= j_next;
        promos_reg     <= promos_next;
        rd_mode_reg    <= rd_mode_next;
        rd_level_reg   <= rd_level_next;
        rd_pos_reg     <= rd_pos_next;
        res_status_reg <= res_status_next;
        res_task_reg   <= res_task_next;
        res_level_reg  <= res_level_next;
        res_dem_reg    <= res_dem_next;
        if ((state_reg == S_DONE) && (!out_valid_reg || m_tready))
        begin
            out_status_reg <= res_status_reg;
            out_task_reg   <= res_task_reg;
            out_level_reg  <= res_level_reg;
            out_dem_reg    <= res_dem_reg;
            out_promos_reg <= promos_reg;
        end
    end

    // queues never hold more than the task slots
    assert property (@(posedge clk) disable iff (!rst_n)
        ((LW+2)'(len_reg[0]) + (LW+2)'(len_reg[1]) + (LW+2)'(len_reg[2])
         + (LW+2)'(len_reg[3])) <= (LW+2)'(NUM_TASKS))
        else $error("queue lengths exceed task slots");

    // a non-empty queue always has a head cell
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_HEAD) && found) |-> chain_end.hit)
        else $error("no head cell for non-empty queue");

    // an ignored or empty result carries no chosen task or demotion
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_status_reg != ST_DONE)) |-> (!out_dem_reg && (out_task_reg == 6'd0)))
        else $error("stray pick fields in result");

endmodule

// File: hdl/mlfq_cell.sv
module mlfq_cell
    import mlfq_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [TW-1:0] cell_idx,
    input  bcast_t        bc,
    input  logic          any_flag,
    input  chain_t        chain_in,
    output chain_t        chain_out
);

    logic [1:0]    mode_reg, mode_next;
    logic [1:0]    level_reg, level_next;
    logic [TW-1:0] pos_reg, pos_next;
    logic [7:0]    slice_reg, slice_next;
    logic [15:0]   wait_reg, wait_next;

    logic          me;
    logic          ready;
    logic          at_lv;
    logic          promo_me;
    logic          head_me;
    logic          dem_me;
    logic          hit_me;
    logic          flag_me;
    logic [7:0]    slice_inc;
    logic [15:0]   wait_inc;
    logic [1:0]    new_clv;

    assign me        = (cell_idx == bc.tsel);
    assign ready     = (mode_reg == MODE_READY);
    assign at_lv     = ready && (level_reg == bc.lv);
    assign slice_inc = (slice_reg == 8'hFF) ? slice_reg : slice_reg + 8'd1;
    assign wait_inc  = (wait_reg == 16'hFFFF) ? wait_reg : wait_reg + 16'd1;
    assign promo_me  = (bc.cmd == CMD_PROMO) && at_lv && (pos_reg == bc.pos)
                       && (wait_reg >= bc.starve_lim);
    assign head_me   = (bc.cmd == CMD_HEAD) && at_lv && (pos_reg == '0);
    assign dem_me    = head_me && (bc.lv != 2'd0) && (slice_inc >= bc.slice_lim);
    assign new_clv   = bc.lv - {1'b0, any_flag};

    always_comb
    begin
        hit_me  = 1'b0;
        flag_me = 1'b0;
        case (bc.cmd)
            CMD_READ:  hit_me = me;
            CMD_PROMO:
            begin
                hit_me  = promo_me;
                flag_me = promo_me;
            end
            CMD_HEAD:
            begin
                hit_me  = head_me;
                flag_me = dem_me;
            end
            default:   hit_me = 1'b0;
        endcase
    end

    always_comb
    begin
        chain_out.hit  = chain_in.hit | hit_me;
        chain_out.flag = chain_in.flag | flag_me;
        if (hit_me)
        begin
            chain_out.idx   = cell_idx;
            chain_out.mode  = mode_reg;
            chain_out.level = level_reg;
            chain_out.pos   = pos_reg;
        end
        else
        begin
            chain_out.idx   = chain_in.idx;
            chain_out.mode  = chain_in.mode;
            chain_out.level = chain_in.level;
            chain_out.pos   = chain_in.pos;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        level_next = level_reg;
        pos_next   = pos_reg;
        slice_next = slice_reg;
        wait_next  = wait_reg;
        case (bc.cmd)
            CMD_ADMIT:
                if (me)
                begin
                    mode_next  = MODE_READY;
                    level_next = TOP_LEVEL;
                    pos_next   = bc.app_pos;
                    slice_next = 8'd0;
                    wait_next  = 16'd0;
                end
            CMD_REMOVE:
                if (me)
                    mode_next = bc.next_mode;
                else if (bc.shift && at_lv && (pos_reg > bc.pos))
                    pos_next = pos_reg - 1'b1;
            CMD_WAKE:
                if (me)
                begin
                    mode_next = MODE_READY;
                    pos_next  = bc.app_pos;
                end
            CMD_PROMO:
                if (promo_me)
                begin
                    level_next = bc.lv + 2'd1;
                    pos_next   = bc.app_pos;
                    slice_next = 8'd0;
                    wait_next  = 16'd0;
                end
                else if (any_flag && at_lv && (pos_reg > bc.pos))
                    pos_next = pos_reg - 1'b1;
            CMD_HEAD:
                if (head_me)
                begin
                    wait_next = 16'd0;
                    if (dem_me)
                    begin
                        level_next = bc.lv - 2'd1;
                        pos_next   = bc.app_pos;
                        slice_next = 8'd0;
                    end
                    else
                        slice_next = slice_inc;
                end
                else
                begin
                    if (any_flag && at_lv && (pos_reg != '0))
                        pos_next = pos_reg - 1'b1;
                    if (ready && (level_reg <= new_clv))
                        wait_next = wait_inc;
                end
            default:
                mode_next = mode_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_UNUSED;
        else
            mode_reg <= mode_next;
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
        pos_reg   <= pos_next;
        slice_reg <= slice_next;
        wait_reg  <= wait_next;
    end

endmodule
